@@ rtl/isd_pkg.sv @@
package isd_pkg;

  // Field and datapath widths
  localparam int COORD_W  = 14;  // signed image coordinate / axis distance
  localparam int SQ_W     = 24;  // one squared axis distance
  localparam int D2_W     = 26;  // squared grid distance
  localparam int SQ_IN_W  = 46;  // radicand: d2 * 810000
  localparam int SQ_OUT_W = 23;  // root width
  localparam int SQ_STEPS = SQ_IN_W / 2;
  localparam int DV_W     = 10;  // divisor 7 * grid_per_metre
  localparam int DV_STEPS = SQ_OUT_W;
  localparam int DELAY_W  = 19;
  localparam int GAIN_W   = 16;

  // Stage counts of the delay path: geometry, root, divide, saturate
  localparam int GEO_LAT = 3;
  localparam int DLY_LAT = GEO_LAT + SQ_STEPS + DV_STEPS + 1;

  localparam logic [GAIN_W-1:0]  Q_ONE      = 16'd32768;
  localparam logic [19:0]        DIST_SCALE = 20'd810000;
  localparam logic [DELAY_W-1:0] DELAY_MAX  = 19'd524287;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_LEN_X  = 3'd0;
  localparam logic [2:0] REG_LEN_Y  = 3'd1;
  localparam logic [2:0] REG_LEN_Z  = 3'd2;
  localparam logic [2:0] REG_GPM    = 3'd3;
  localparam logic [2:0] REG_WGAIN_X = 3'd4;
  localparam logic [2:0] REG_WGAIN_Y = 3'd5;
  localparam logic [2:0] REG_WGAIN_Z = 3'd6;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [7:0]  len_x;
    logic [7:0]  len_y;
    logic [7:0]  len_z;
    logic [6:0]  grid_per_metre;
    logic [31:0] wall_gain_x;
    logic [31:0] wall_gain_y;
    logic [31:0] wall_gain_z;
  } cfg_t;

  // Clamp a 5-bit two's complement offset to +-lim
  function automatic logic [4:0] clamp_off(input logic [4:0] p, input logic [4:0] lim);
    logic signed [4:0] ps;
    logic signed [4:0] ls;
    ps = signed'(p);
    ls = signed'(lim);
    if (ps > ls) return lim;
    if (ps < -ls) return 5'(-ls);
    return p;
  endfunction

  // Image coordinate c + p*L, mirrored about the room centre for odd p
  function automatic logic [COORD_W-1:0] image_coord(input logic [7:0] c,
                                                     input logic [4:0] p,
                                                     input logic [7:0] len);
    logic signed [COORD_W-1:0] pe;
    logic signed [COORD_W-1:0] le;
    logic signed [COORD_W-1:0] ce;
    logic signed [COORD_W-1:0] r;
    pe = signed'({{(COORD_W-5){p[4]}}, p});
    le = signed'({{(COORD_W-8){1'b0}}, len});
    ce = signed'({{(COORD_W-8){1'b0}}, c});
    r  = ce + pe * le;
    if (p[0]) begin
      r = r + signed'({{(COORD_W-8){1'b0}}, len[7:1], 1'b0})
            - signed'({{(COORD_W-9){1'b0}}, c, 1'b0});
    end
    return r;
  endfunction

  // Q1.15 product with rounding, saturated to one
  function automatic logic [GAIN_W-1:0] qmul(input logic [GAIN_W-1:0] a,
                                             input logic [GAIN_W-1:0] b);
    logic [32:0] p;
    logic [17:0] s;
    p = 33'(a) * 33'(b) + 33'd16384;
    s = p[32:15];
    if (s > 18'(Q_ONE)) return Q_ONE;
    return s[GAIN_W-1:0];
  endfunction

endpackage

@@ rtl/isd_geom.sv @@
module isd_geom #(
  parameter int MAX_ORDER = 8
) (
  input  logic                        clk,
  input  logic                        adv,
  input  isd_pkg::cfg_t               cfg,
  input  logic [4:0]                  off_x,
  input  logic [4:0]                  off_y,
  input  logic [4:0]                  off_z,
  input  logic [7:0]                  lis_x,
  input  logic [7:0]                  lis_y,
  input  logic [7:0]                  lis_z,
  output logic [isd_pkg::SQ_IN_W-1:0] rad_left,
  output logic [isd_pkg::SQ_IN_W-1:0] rad_right
);

  localparam int CW = isd_pkg::COORD_W;

  logic [CW-1:0] ix_r, iy_r, iz_r;
  logic [isd_pkg::SQ_W-1:0] sq_xl_r, sq_xr_r, sq_y_r, sq_z_r;
  logic [isd_pkg::SQ_IN_W-1:0] rad_l_r, rad_r_r;

  logic signed [CW-1:0] dxl, dxr, dy, dz;
  logic signed [2*CW-1:0] pxl, pxr, py, pz;
  logic [7:0] sxl, sxr, sy;
  logic [isd_pkg::D2_W-1:0] d2l, d2r;

  // Speaker positions
  always_comb begin
    sxl = {2'b0, cfg.len_x[7:2]};
    sxr = 8'({2'b0, cfg.len_x[7:2]} * 8'd3);
    sy  = {1'b0, cfg.len_y[7:1]};
  end

  // Stage 1: image position
  always_ff @(posedge clk) begin
    if (adv) begin
      ix_r <= isd_pkg::image_coord(lis_x,
                isd_pkg::clamp_off(off_x, 5'(MAX_ORDER)), cfg.len_x);
      iy_r <= isd_pkg::image_coord(lis_y,
                isd_pkg::clamp_off(off_y, 5'(MAX_ORDER)), cfg.len_y);
      iz_r <= isd_pkg::image_coord(lis_z,
                isd_pkg::clamp_off(off_z, 5'(MAX_ORDER)), cfg.len_z);
    end
  end

  // Stage 2: squared axis distances
  always_comb begin
    dxl = signed'(ix_r) - signed'({{(CW-8){1'b0}}, sxl});
    dxr = signed'(ix_r) - signed'({{(CW-8){1'b0}}, sxr});
    dy  = signed'(iy_r) - signed'({{(CW-8){1'b0}}, sy});
    dz  = signed'(iz_r) - signed'(CW'(1));
    pxl = dxl * dxl;
    pxr = dxr * dxr;
    py  = dy * dy;
    pz  = dz * dz;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_xl_r <= pxl[isd_pkg::SQ_W-1:0];
      sq_xr_r <= pxr[isd_pkg::SQ_W-1:0];
      sq_y_r  <= py[isd_pkg::SQ_W-1:0];
      sq_z_r  <= pz[isd_pkg::SQ_W-1:0];
    end
  end

  // Stage 3: squared distance, scaled for the root
  always_comb begin
    d2l = isd_pkg::D2_W'(sq_xl_r) + isd_pkg::D2_W'(sq_y_r) + isd_pkg::D2_W'(sq_z_r);
    d2r = isd_pkg::D2_W'(sq_xr_r) + isd_pkg::D2_W'(sq_y_r) + isd_pkg::D2_W'(sq_z_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_l_r <= isd_pkg::SQ_IN_W'(d2l) * isd_pkg::SQ_IN_W'(isd_pkg::DIST_SCALE);
      rad_r_r <= isd_pkg::SQ_IN_W'(d2r) * isd_pkg::SQ_IN_W'(isd_pkg::DIST_SCALE);
    end
  end

  assign rad_left  = rad_l_r;
  assign rad_right = rad_r_r;

endmodule

@@ rtl/isd_sqrt.sv @@
module isd_sqrt (
  input  logic                         clk,
  input  logic                         adv,
  input  logic [isd_pkg::SQ_IN_W-1:0]  rad,
  output logic [isd_pkg::SQ_OUT_W-1:0] root
);

  localparam int N  = isd_pkg::SQ_STEPS;
  localparam int AW = isd_pkg::SQ_IN_W + 1;

  logic [AW-1:0] v_r   [N];
  logic [AW-1:0] res_r [N];

  // One result bit per stage, restoring digit-by-digit root
  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [AW-1:0] BIT = AW'(1) << (2 * (N - 1 - k));
    logic [AW-1:0] v_in, res_in, t, v_nxt, res_nxt;

    if (k == 0) begin : g_first
      assign v_in   = AW'(rad);
      assign res_in = '0;
    end else begin : g_next
      assign v_in   = v_r[k-1];
      assign res_in = res_r[k-1];
    end

    always_comb begin
      t = res_in + BIT;
      if (v_in >= t) begin
        v_nxt   = v_in - t;
        res_nxt = (res_in >> 1) + BIT;
      end else begin
        v_nxt   = v_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        v_r[k]   <= v_nxt;
        res_r[k] <= res_nxt;
      end
    end
  end

  assign root = res_r[N-1][isd_pkg::SQ_OUT_W-1:0];

endmodule

@@ rtl/isd_div.sv @@
module isd_div (
  input  logic                         clk,
  input  logic                         adv,
  input  logic [isd_pkg::SQ_OUT_W-1:0] num,
  input  logic [isd_pkg::DV_W-1:0]     den,
  output logic [isd_pkg::DELAY_W-1:0]  delay
);

  localparam int N  = isd_pkg::DV_STEPS;
  localparam int QW = isd_pkg::SQ_OUT_W;
  localparam int RW = isd_pkg::DV_W;

  logic [RW-1:0] rem_r [N];
  logic [QW-1:0] num_r [N];
  logic [QW-1:0] quo_r [N];
  logic [isd_pkg::DELAY_W-1:0] dly_r;

  // Restoring division, one quotient bit per stage
  for (genvar k = 0; k < N; k++) begin : g_step
    logic [RW-1:0] rem_in, rem_nxt;
    logic [QW-1:0] num_in, quo_in;
    logic [RW:0]   trial;
    logic          qb;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign num_in = num_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    always_comb begin
      trial = {rem_in, num_in[QW-1]};
      qb    = trial >= {1'b0, den};
      if (qb) rem_nxt = RW'(trial - {1'b0, den});
      else    rem_nxt = trial[RW-1:0];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= rem_nxt;
        num_r[k] <= {num_in[QW-2:0], 1'b0};
        quo_r[k] <= {quo_in[QW-2:0], qb};
      end
    end
  end

  // Saturate to the delay range
  always_ff @(posedge clk) begin
    if (adv) begin
      if (|quo_r[N-1][QW-1:isd_pkg::DELAY_W]) dly_r <= isd_pkg::DELAY_MAX;
      else dly_r <= quo_r[N-1][isd_pkg::DELAY_W-1:0];
    end
  end

  assign delay = dly_r;

endmodule

@@ rtl/isd_gain.sv @@
module isd_gain #(
  parameter int MAX_ORDER = 8
) (
  input  logic                        clk,
  input  logic                        adv,
  input  isd_pkg::cfg_t               cfg,
  input  logic [4:0]                  off_x,
  input  logic [4:0]                  off_y,
  input  logic [4:0]                  off_z,
  output logic [isd_pkg::GAIN_W-1:0]  gain
);

  localparam int SLOTS = 2 * MAX_ORDER + 1;
  localparam int NSLOT = 3 * SLOTS;
  localparam int GW    = isd_pkg::GAIN_W;

  logic [GW-1:0] g_r  [NSLOT];
  logic [4:0]    px_r [NSLOT];
  logic [4:0]    py_r [NSLOT];
  logic [4:0]    pz_r [NSLOT];

  // One wall reflection slot per stage: x slots, then y, then z
  for (genvar s = 0; s < NSLOT; s++) begin : g_slot
    localparam int AX = s / SLOTS;
    localparam int J  = s % SLOTS;
    logic [GW-1:0] g_in, fac, g_nxt;
    logic [4:0]    ix, iy, iz, p_ax;
    logic [31:0]   wg;
    logic [3:0]    mag;
    logic          use_f;

    if (s == 0) begin : g_first
      assign g_in = isd_pkg::Q_ONE;
      assign ix   = isd_pkg::clamp_off(off_x, 5'(MAX_ORDER));
      assign iy   = isd_pkg::clamp_off(off_y, 5'(MAX_ORDER));
      assign iz   = isd_pkg::clamp_off(off_z, 5'(MAX_ORDER));
    end else begin : g_next
      assign g_in = g_r[s-1];
      assign ix   = px_r[s-1];
      assign iy   = py_r[s-1];
      assign iz   = pz_r[s-1];
    end

    always_comb begin
      if (AX == 0) begin
        p_ax = ix;
        wg   = cfg.wall_gain_x;
      end else if (AX == 1) begin
        p_ax = iy;
        wg   = cfg.wall_gain_y;
      end else begin
        p_ax = iz;
        wg   = cfg.wall_gain_z;
      end
      mag = p_ax[4] ? 4'(-p_ax) : p_ax[3:0];
      if (J < 2 * MAX_ORDER) begin
        // pair slots: negative wall, then positive wall
        use_f = {1'b0, mag[3:1]} > 4'(J / 2);
        fac   = (J % 2 == 0) ? wg[15:0] : wg[31:16];
      end else begin
        // odd order: far wall on the side of travel
        use_f = mag[0];
        fac   = p_ax[4] ? wg[31:16] : wg[15:0];
      end
      g_nxt = use_f ? isd_pkg::qmul(g_in, fac) : g_in;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        g_r[s]  <= g_nxt;
        px_r[s] <= ix;
        py_r[s] <= iy;
        pz_r[s] <= iz;
      end
    end
  end

  assign gain = g_r[NSLOT-1];

endmodule

@@ rtl/image_source_delay_gain.sv @@
// Throughput: one transaction per cycle while no stall holds the result side; set by the
// single-step root, divide and gain multiply stages, all advancing together.
// A stall on the result side freezes the whole pipeline; no item is dropped.
// Reset (synchronous, rst_n low) clears all valid bits and loads the register defaults.
module image_source_delay_gain #(
  parameter int MAX_ORDER = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_offset_x,
  input  logic [4:0]  in_offset_y,
  input  logic [4:0]  in_offset_z,
  input  logic [7:0]  in_listener_x,
  input  logic [7:0]  in_listener_y,
  input  logic [7:0]  in_listener_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [18:0] out_delay_left,
  output logic [18:0] out_delay_right,
  output logic [15:0] out_gain,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int GAIN_LAT = 3 * (2 * MAX_ORDER + 1);
  localparam int TOTAL    = (GAIN_LAT > isd_pkg::DLY_LAT) ? GAIN_LAT : isd_pkg::DLY_LAT;
  localparam int PAD_G    = TOTAL - GAIN_LAT;
  localparam int PAD_D    = TOTAL - isd_pkg::DLY_LAT;
  localparam int DW       = isd_pkg::DELAY_W;

  isd_pkg::cfg_t cfg_r;
  logic [TOTAL-1:0] vld_r;
  logic adv;
  logic [6:0] gpm;
  logic [isd_pkg::DV_W-1:0] den;
  logic [isd_pkg::SQ_IN_W-1:0] rad_l, rad_r;
  logic [isd_pkg::SQ_OUT_W-1:0] root_l, root_r;
  logic [DW-1:0] dly_l, dly_r;
  logic [isd_pkg::GAIN_W-1:0] gain_raw;
  logic [2*DW-1:0] dly_out;
  logic [isd_pkg::GAIN_W-1:0] gain_out;

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.len_x          <= 8'd6;
      cfg_r.len_y          <= 8'd20;
      cfg_r.len_z          <= 8'd20;
      cfg_r.grid_per_metre <= 7'd1;
      cfg_r.wall_gain_x    <= 32'd1932751667;
      cfg_r.wall_gain_y    <= 32'd1932745114;
      cfg_r.wall_gain_z    <= 32'd1932751667;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        isd_pkg::REG_LEN_X:   cfg_r.len_x          <= pwdata[7:0];
        isd_pkg::REG_LEN_Y:   cfg_r.len_y          <= pwdata[7:0];
        isd_pkg::REG_LEN_Z:   cfg_r.len_z          <= pwdata[7:0];
        isd_pkg::REG_GPM:     cfg_r.grid_per_metre <= pwdata[6:0];
        isd_pkg::REG_WGAIN_X: cfg_r.wall_gain_x    <= pwdata;
        isd_pkg::REG_WGAIN_Y: cfg_r.wall_gain_y    <= pwdata;
        isd_pkg::REG_WGAIN_Z: cfg_r.wall_gain_z    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      isd_pkg::REG_LEN_X:   prdata = {24'd0, cfg_r.len_x};
      isd_pkg::REG_LEN_Y:   prdata = {24'd0, cfg_r.len_y};
      isd_pkg::REG_LEN_Z:   prdata = {24'd0, cfg_r.len_z};
      isd_pkg::REG_GPM:     prdata = {25'd0, cfg_r.grid_per_metre};
      isd_pkg::REG_WGAIN_X: prdata = cfg_r.wall_gain_x;
      isd_pkg::REG_WGAIN_Y: prdata = cfg_r.wall_gain_y;
      isd_pkg::REG_WGAIN_Z: prdata = cfg_r.wall_gain_z;
      default:              prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Pipeline advance: the last stage is the output register
  assign adv      = !vld_r[TOTAL-1] || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[TOTAL-2:0], in_valid};
  end

  // Divisor 7 * grid_per_metre, zero taken as one
  always_comb begin
    gpm = (cfg_r.grid_per_metre == 7'd0) ? 7'd1 : cfg_r.grid_per_metre;
    den = isd_pkg::DV_W'({gpm, 3'b000}) - isd_pkg::DV_W'(gpm);
  end

  isd_geom #(.MAX_ORDER(MAX_ORDER)) u_geom (
    .clk(clk), .adv(adv), .cfg(cfg_r),
    .off_x(in_offset_x), .off_y(in_offset_y), .off_z(in_offset_z),
    .lis_x(in_listener_x), .lis_y(in_listener_y), .lis_z(in_listener_z),
    .rad_left(rad_l), .rad_right(rad_r)
  );

  isd_sqrt u_sqrt_l (.clk(clk), .adv(adv), .rad(rad_l), .root(root_l));
  isd_sqrt u_sqrt_r (.clk(clk), .adv(adv), .rad(rad_r), .root(root_r));

  isd_div u_div_l (.clk(clk), .adv(adv), .num(root_l), .den(den), .delay(dly_l));
  isd_div u_div_r (.clk(clk), .adv(adv), .num(root_r), .den(den), .delay(dly_r));

  isd_gain #(.MAX_ORDER(MAX_ORDER)) u_gain (
    .clk(clk), .adv(adv), .cfg(cfg_r),
    .off_x(in_offset_x), .off_y(in_offset_y), .off_z(in_offset_z),
    .gain(gain_raw)
  );

  // Align the shorter path to the longer one
  if (PAD_D > 0) begin : g_pad_d
    logic [2*DW-1:0] pad_r [PAD_D];
    always_ff @(posedge clk) begin
      if (adv) begin
        pad_r[0] <= {dly_l, dly_r};
        for (int i = 1; i < PAD_D; i++) pad_r[i] <= pad_r[i-1];
      end
    end
    assign dly_out = pad_r[PAD_D-1];
  end else begin : g_nopad_d
    assign dly_out = {dly_l, dly_r};
  end

  if (PAD_G > 0) begin : g_pad_g
    logic [isd_pkg::GAIN_W-1:0] pad_r [PAD_G];
    always_ff @(posedge clk) begin
      if (adv) begin
        pad_r[0] <= gain_raw;
        for (int i = 1; i < PAD_G; i++) pad_r[i] <= pad_r[i-1];
      end
    end
    assign gain_out = pad_r[PAD_G-1];
  end else begin : g_nopad_g
    assign gain_out = gain_raw;
  end

  assign out_valid       = vld_r[TOTAL-1];
  assign out_delay_left  = dly_out[2*DW-1:DW];
  assign out_delay_right = dly_out[DW-1:0];
  assign out_gain        = gain_out;

endmodule

@@ rtl/isd_check.sv @@
module isd_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [18:0] out_delay_left,
  input logic [18:0] out_delay_right,
  input logic [15:0] out_gain,
  input logic        pready
);

  // Stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_delay_left)
      && $stable(out_delay_right) && $stable(out_gain))
    else $error("stalled result changed");

  // Input is held off only while a finished result is blocked
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to output backpressure");

  // Gain never exceeds one
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_gain <= 16'd32768)
    else $error("gain above one");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

  // Configuration port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind image_source_delay_gain isd_check u_isd_check (.*);
